// ===== hdl/fbds_pkg.sv =====
// Shared constants, types and address helpers of the framebuffer difference sync block.
package fbds_pkg;

  localparam int LINES           = 64;
  localparam int BYTES_PER_LINE  = 16;
  localparam int PIXELS_PER_LINE = 128;
  localparam int LOOKAHEAD       = 3;

  localparam int DEPTH  = LINES * BYTES_PER_LINE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LROW_W = $clog2(LINES);
  localparam int BCOL_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam int HALF   = LINES / 2;
  localparam int PROW_W = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int POS_N  = 2 * BYTES_PER_LINE;
  localparam int CNT_W  = $clog2(POS_N + 1);

  localparam int KIND_W    = 2;
  localparam int X_W       = 7;
  localparam int Y_W       = 6;
  localparam int PROW_IN_W = 5;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 4;
  localparam int DATA_W    = 8;

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd2;

  localparam logic CMD_ADDR = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR_ALL,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CLEAR_WORK,
    ST_LOAD,
    ST_WALK,
    ST_DATA,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] data;
  } res_t;

  function automatic logic [LROW_W-1:0] pos_row(logic [PROW_W-1:0] prow,
                                                logic [CNT_W-1:0] pos);
    if (32'(pos) < BYTES_PER_LINE) begin
      pos_row = LROW_W'(prow);
    end else begin
      pos_row = LROW_W'(32'(prow) + HALF);
    end
  endfunction

  function automatic logic [BCOL_W-1:0] pos_col(logic [CNT_W-1:0] pos);
    if (32'(pos) < BYTES_PER_LINE) begin
      pos_col = BCOL_W'(pos);
    end else begin
      pos_col = BCOL_W'(32'(pos) - BYTES_PER_LINE);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(logic [LROW_W-1:0] row,
                                                logic [BCOL_W-1:0] col);
    addr_of = ADDR_W'(32'(row) * BYTES_PER_LINE + 32'(col));
  endfunction

endpackage

// ===== hdl/fbds_result_stage.sv =====
// Output stage that holds one result back so the final result of a row sync can be marked.
module fbds_result_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fbds_pkg::res_t res_i,
  input  logic           flush_i,
  output logic           valid_o,
  output fbds_pkg::res_t res_o,
  output logic           last_o
);
  import fbds_pkg::*;

  logic pend_vld_q;
  res_t pend_q;
  logic out_vld_q;
  res_t out_q;
  logic last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
      if (push_i) begin
        out_vld_q  <= pend_vld_q;
        pend_vld_q <= 1'b1;
      end else if (flush_i) begin
        out_vld_q  <= pend_vld_q;
        last_q     <= pend_vld_q;
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_q <= res_i;
      out_q  <= pend_q;
    end else if (flush_i) begin
      out_q <= pend_q;
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_q;
  assign last_o  = last_q;

endmodule

// ===== hdl/framebuffer_diff_sync_core.sv =====
// Top level of the framebuffer difference sync block.
// An item is taken when start is high and busy is low, and results leave on res_valid_o,
// one cycle each, with no way for the receiver to hold them off. After reset the block
// clears both 1024-byte stores, one byte a cycle, and stays busy until both are clear.
// A pixel item keeps the block busy while it reads, then modifies and writes, the store
// byte, and a clear item clears the 1024-byte work store, one byte per cycle. A row sync first
// reads the 32 bytes of the panel row from both stores, one address per cycle,
// then walks the row one position a cycle, pausing the walk wherever an address
// command precedes a byte, and ends with a flush step. Each result is held until the
// next one is generated or the row ends, so the final one appears as busy drops.
module framebuffer_diff_sync_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [fbds_pkg::KIND_W-1:0]    kind_i,
  input  logic [fbds_pkg::X_W-1:0]       pixel_x_i,
  input  logic [fbds_pkg::Y_W-1:0]       pixel_y_i,
  input  logic                           pixel_value_i,
  input  logic [fbds_pkg::PROW_IN_W-1:0] panel_row_i,
  input  logic                           optimize_i,
  output logic                           res_valid_o,
  output logic                           cmd_o,
  output logic [fbds_pkg::ROW_W-1:0]     addr_row_o,
  output logic [fbds_pkg::COL_W-1:0]     addr_col_o,
  output logic [fbds_pkg::DATA_W-1:0]    data_o,
  output logic                           last_o
);
  import fbds_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                skip_q, skip_d;
  logic                rd_vld_q;
  logic                opt_q;
  logic [PROW_W-1:0]   prow_q;
  logic [ADDR_W-1:0]   pix_addr_q;
  logic [2:0]          pix_bit_q;
  logic                pix_val_q;
  logic [DATA_W-1:0]   byte_q [POS_N];
  logic [POS_N-1:0]    diff_q;

  logic [DATA_W-1:0]   work_mem  [DEPTH];
  logic [DATA_W-1:0]   shown_mem [DEPTH];
  logic [DATA_W-1:0]   work_rd_q;
  logic [DATA_W-1:0]   shown_rd_q;

  logic                accept;
  logic                pix_ok;
  logic                row_ok;
  logic                walk_last;
  logic                clr_last;
  logic                quiet;
  logic [ADDR_W-1:0]   pos_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                work_we;
  logic [ADDR_W-1:0]   work_wa;
  logic [DATA_W-1:0]   work_wd;
  logic                shown_we;
  logic                ld_shift;
  logic                walk_shift;
  logic                push;
  logic                flush;
  res_t                res;
  res_t                res_out;
  logic [DATA_W-1:0]   pix_mask;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign pix_ok    = (32'(pixel_x_i) < PIXELS_PER_LINE) &&
                     (32'(pixel_x_i >> 3) < BYTES_PER_LINE) &&
                     (32'(pixel_y_i) < LINES);
  assign row_ok    = (32'(panel_row_i) < HALF);
  assign walk_last = (pos_q == CNT_W'(POS_N - 1));
  assign clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
  assign pos_addr  = addr_of(pos_row(prow_q, pos_q), pos_col(pos_q));
  assign pix_mask  = 8'h80 >> pix_bit_q;

  always_comb begin
    quiet = 1'b1;
    for (int d = 0; d < LOOKAHEAD; d++) begin
      if (d < POS_N) begin
        if (diff_q[d]) begin
          quiet = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR_ALL: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_PIXEL: if (pix_ok) state_d = ST_PIX_RD;
            KIND_CLEAR: state_d = ST_CLEAR_WORK;
            KIND_SYNC:  if (row_ok) state_d = ST_LOAD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:     state_d = ST_PIX_WR;
      ST_PIX_WR:     state_d = ST_IDLE;
      ST_CLEAR_WORK: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_LOAD: begin
        if (pos_q == CNT_W'(POS_N)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (skip_q && !(opt_q && !diff_q[0])) begin
          state_d = ST_DATA;
        end else if (walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_DATA: begin
        state_d = walk_last ? ST_FLUSH : ST_WALK;
      end
      ST_FLUSH:      state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d      = clr_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    rd_addr    = pos_addr;
    work_we    = 1'b0;
    work_wa    = clr_q;
    work_wd    = '0;
    shown_we   = 1'b0;
    ld_shift   = 1'b0;
    walk_shift = 1'b0;
    push       = 1'b0;
    flush      = 1'b0;
    res.cmd    = CMD_DATA;
    res.row    = '0;
    res.col    = '0;
    res.data   = byte_q[0];
    case (state_q)
      ST_CLEAR_ALL: begin
        work_we  = 1'b1;
        shown_we = 1'b1;
        clr_d    = clr_q + 1'b1;
      end
      ST_IDLE: begin
        clr_d  = '0;
        pos_d  = '0;
        skip_d = 1'b1;
      end
      ST_PIX_RD: begin
        rd_addr = pix_addr_q;
      end
      ST_PIX_WR: begin
        work_we = 1'b1;
        work_wa = pix_addr_q;
        work_wd = pix_val_q ? (work_rd_q | pix_mask) : (work_rd_q & ~pix_mask);
      end
      ST_CLEAR_WORK: begin
        work_we = 1'b1;
        clr_d   = clr_q + 1'b1;
      end
      ST_LOAD: begin
        ld_shift = rd_vld_q;
        pos_d    = (pos_q == CNT_W'(POS_N)) ? '0 : pos_q + 1'b1;
      end
      ST_WALK: begin
        if (skip_q) begin
          if (opt_q && !diff_q[0]) begin
            walk_shift = 1'b1;
            pos_d      = pos_q + 1'b1;
          end else begin
            push     = 1'b1;
            res.cmd  = CMD_ADDR;
            res.row  = ROW_W'(pos_row(prow_q, pos_q));
            res.col  = COL_W'(pos_col(pos_q));
            res.data = '0;
            skip_d   = 1'b0;
          end
        end else if (opt_q && quiet) begin
          skip_d     = 1'b1;
          walk_shift = 1'b1;
          pos_d      = pos_q + 1'b1;
        end else begin
          push       = 1'b1;
          shown_we   = 1'b1;
          walk_shift = 1'b1;
          pos_d      = pos_q + 1'b1;
        end
      end
      ST_DATA: begin
        push       = 1'b1;
        shown_we   = 1'b1;
        walk_shift = 1'b1;
        pos_d      = pos_q + 1'b1;
      end
      ST_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
        flush = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR_ALL;
      clr_q    <= '0;
      pos_q    <= '0;
      skip_q   <= 1'b1;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pos_q    <= pos_d;
      skip_q   <= skip_d;
      rd_vld_q <= (state_q == ST_LOAD) && (pos_q != CNT_W'(POS_N));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opt_q      <= optimize_i;
      prow_q     <= PROW_W'(panel_row_i);
      pix_addr_q <= addr_of(LROW_W'(pixel_y_i), BCOL_W'(pixel_x_i >> 3));
      pix_bit_q  <= pixel_x_i[2:0];
      pix_val_q  <= pixel_value_i;
    end
    if (ld_shift || walk_shift) begin
      for (int i = 0; i < POS_N - 1; i++) begin
        byte_q[i] <= byte_q[i+1];
        diff_q[i] <= diff_q[i+1];
      end
      byte_q[POS_N-1] <= ld_shift ? work_rd_q : '0;
      diff_q[POS_N-1] <= ld_shift && (work_rd_q != shown_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    work_rd_q  <= work_mem[rd_addr];
    shown_rd_q <= shown_mem[rd_addr];
    if (work_we) begin
      work_mem[work_wa] <= work_wd;
    end
    if (shown_we) begin
      shown_mem[(state_q == ST_CLEAR_ALL) ? clr_q : pos_addr] <=
        (state_q == ST_CLEAR_ALL) ? '0 : byte_q[0];
    end
  end

  fbds_result_stage u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .flush_i (flush),
    .valid_o (res_valid_o),
    .res_o   (res_out),
    .last_o  (last_o)
  );

  assign cmd_o      = res_out.cmd;
  assign addr_row_o = res_out.row;
  assign addr_col_o = res_out.col;
  assign data_o     = res_out.data;

endmodule

// ===== hdl/fbds_checker.sv =====
// Port-level checks of the framebuffer difference sync block and their binding.
module fbds_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           res_valid_o,
  input logic                           cmd_o,
  input logic [fbds_pkg::ROW_W-1:0]     addr_row_o,
  input logic [fbds_pkg::COL_W-1:0]     addr_col_o,
  input logic [fbds_pkg::DATA_W-1:0]    data_o,
  input logic                           last_o
);
  import fbds_pkg::*;

  // A result only ever follows a cycle of work.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  a_addr_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cmd_o == CMD_ADDR) |-> (data_o == '0))
    else $error("address item carries data");

  a_data_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cmd_o == CMD_DATA) |-> (addr_row_o == '0 && addr_col_o == '0))
    else $error("data item carries an address");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !res_valid_o)
    else $error("result after the final item of a row sync");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !res_valid_o)
    else $error("result right after an accepted item");

endmodule

bind framebuffer_diff_sync_core fbds_checker u_fbds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .cmd_o       (cmd_o),
  .addr_row_o  (addr_row_o),
  .addr_col_o  (addr_col_o),
  .data_o      (data_o),
  .last_o      (last_o)
);
